// ----- design/tti_pkg.sv -----
// shared constants for the trie insert and lookup block
// no dependencies; imported by every module of the block
`default_nettype none

package tti_pkg;

    localparam int unsigned MAX_NODES_DEF = 256;
    localparam int unsigned SYMBOLS       = 256;
    localparam int unsigned SYM_W         = 8;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

endpackage

`default_nettype wire

// ----- design/tti_byte_if.sv -----
// valid/ready channel carrying one word byte per item
// depends on tti_pkg for the symbol width
`default_nettype none

interface tti_byte_if
    import tti_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             func;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output func, output symbol, output last, input ready);
    modport sink   (input valid, input func, input symbol, input last, output ready);
endinterface

`default_nettype wire

// ----- design/tti_result_if.sv -----
// valid/ready channel carrying one result item per word
// no dependencies
`default_nettype none

interface tti_result_if;
    logic valid;
    logic ready;
    logic found;
    logic full_res;

    modport source (output valid, output found, output full_res, input ready);
    modport sink   (input valid, input found, input full_res, output ready);
endinterface

`default_nettype wire

// ----- design/tti_child_mem.sv -----
// child pointer table: one synchronous ram, one entry per node and symbol
// sweeps every entry to zero after reset; depends on tti_pkg
`default_nettype none

module tti_child_mem
    import tti_pkg::*;
#(
    parameter int unsigned MAX_NODES = MAX_NODES_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               rd_en,
    input  wire logic                               wr_en,
    input  wire logic [$clog2(MAX_NODES)+SYM_W-1:0] addr,
    input  wire logic [$clog2(MAX_NODES)-1:0]       wdata,
    output logic      [$clog2(MAX_NODES)-1:0]       rdata,
    output logic                                    busy
);

    localparam int unsigned NW    = $clog2(MAX_NODES);
    localparam int unsigned AW    = NW + SYM_W;
    localparam int unsigned DEPTH = MAX_NODES * SYMBOLS;

    logic [NW-1:0] mem [DEPTH];
    logic [NW-1:0] rdata_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

`default_nettype wire

// ----- design/tti_mark_mem.sv -----
// end-of-word marks: one synchronous ram, one bit per node
// sweeps every mark to zero after reset; depends on tti_pkg
`default_nettype none

module tti_mark_mem
    import tti_pkg::*;
#(
    parameter int unsigned MAX_NODES = MAX_NODES_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rd_en,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(MAX_NODES)-1:0] addr,
    output logic                              rdata,
    output logic                              busy
);

    localparam int unsigned NW = $clog2(MAX_NODES);

    logic          mem [MAX_NODES];
    logic          rdata_reg;
    logic [NW-1:0] clr_addr_reg;
    logic          clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == NW'(MAX_NODES - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[addr] <= 1'b1;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

`default_nettype wire

// ----- design/trie_table_insert_lookup.sv -----
// top level of the trie insert and lookup block: walk controller and result register
// depends on tti_pkg, tti_byte_if, tti_result_if, tti_child_mem, tti_mark_mem
//
//   channel    dir  payload                   item
//   word_byte  in   func, symbol[7:0], last   one byte of a word
//   result     out  found, full_res           one per word, on its last byte
//
// each byte is accepted in ST_IDLE, which starts its read of the one-port child table;
// the registered entry is used in ST_WALK, and the next byte is taken back in ST_IDLE
// the last byte then passes ST_RESULT; a lookup that reaches its node passes ST_MARK
// (mark read) first; after reset the child table is swept to zero in ST_CLEAR
// a result waits in the output register; bytes of the next word are still accepted,
// and only the next result waits until the register is taken
`default_nettype none

module trie_table_insert_lookup
    import tti_pkg::*;
#(
    parameter int unsigned MAX_NODES = MAX_NODES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    tti_byte_if.sink      word_byte,
    tti_result_if.source  result
);

    localparam int unsigned NW = $clog2(MAX_NODES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_MARK,
        ST_RESULT
    } state_t;

    state_t             state_reg;
    logic               func_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic               last_reg;
    logic [NW-1:0]      cur_reg;
    logic               failed_reg;
    logic [NW:0]        next_free_reg;
    logic               pend_found_reg;
    logic               pend_full_reg;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic               out_full_reg;

    logic               child_rd_en;
    logic               child_wr_en;
    logic [NW+SYM_W-1:0] child_addr;
    logic [NW-1:0]      child_rdata;
    logic               child_busy;
    logic               mark_rd_en;
    logic               mark_wr_en;
    logic               mark_rdata;
    logic               mark_busy;

    logic               accept;
    logic               hit;
    logic               table_full;
    logic               fail_now;
    logic               alloc;
    logic [NW-1:0]      node_walk;
    logic               out_free;
    logic               load_out;

    assign accept     = word_byte.valid && word_byte.ready;
    assign hit        = (child_rdata != '0);
    assign table_full = (next_free_reg == (NW+1)'(MAX_NODES));
    assign fail_now   = failed_reg || (!hit && (func_reg == FUNC_LOOKUP || table_full));
    assign alloc      = !failed_reg && !hit && func_reg == FUNC_INSERT && !table_full;
    assign node_walk  = fail_now ? cur_reg : (hit ? child_rdata : next_free_reg[NW-1:0]);
    assign out_free   = !out_valid_reg || result.ready;
    assign load_out   = (state_reg == ST_RESULT) && out_free;

    assign child_rd_en = accept;
    assign child_wr_en = (state_reg == ST_WALK) && alloc;
    assign child_addr  = (state_reg == ST_WALK) ? {cur_reg, sym_reg}
                                                : {cur_reg, word_byte.symbol};
    assign mark_rd_en  = (state_reg == ST_WALK) && last_reg && !fail_now
                         && func_reg == FUNC_LOOKUP;
    assign mark_wr_en  = (state_reg == ST_WALK) && last_reg && !fail_now
                         && func_reg == FUNC_INSERT;

    tti_child_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_child_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (child_rd_en),
        .wr_en (child_wr_en),
        .addr  (child_addr),
        .wdata (next_free_reg[NW-1:0]),
        .rdata (child_rdata),
        .busy  (child_busy)
    );

    tti_mark_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_mark_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (mark_rd_en),
        .wr_en (mark_wr_en),
        .addr  (node_walk),
        .rdata (mark_rdata),
        .busy  (mark_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            func_reg       <= FUNC_INSERT;
            sym_reg        <= '0;
            last_reg       <= 1'b0;
            cur_reg        <= '0;
            failed_reg     <= 1'b0;
            next_free_reg  <= (NW+1)'(1);
            pend_found_reg <= 1'b0;
            pend_full_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_found_reg <= pend_found_reg;
                out_full_reg  <= pend_full_reg;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (!child_busy && !mark_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg  <= word_byte.func;
                        sym_reg   <= word_byte.symbol;
                        last_reg  <= word_byte.last;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (alloc)
                    begin
                        next_free_reg <= next_free_reg + 1'b1;
                    end
                    if (!last_reg)
                    begin
                        cur_reg    <= node_walk;
                        failed_reg <= fail_now;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        cur_reg    <= '0;
                        failed_reg <= 1'b0;
                        if (func_reg == FUNC_LOOKUP && !fail_now)
                        begin
                            state_reg <= ST_MARK;
                        end
                        else
                        begin
                            pend_found_reg <= 1'b0;
                            pend_full_reg  <= (func_reg == FUNC_INSERT) && fail_now;
                            state_reg      <= ST_RESULT;
                        end
                    end
                end
                ST_MARK:
                begin
                    pend_found_reg <= mark_rdata;
                    pend_full_reg  <= 1'b0;
                    state_reg      <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign word_byte.ready = (state_reg == ST_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.found    = out_found_reg;
    assign result.full_res = out_full_reg;

    // the walk never stands on a node that has not been handed out
    a_cur_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_reg} < next_free_reg)
        else $error("current node beyond allocated nodes");

    a_next_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg != '0 && next_free_reg <= (NW+1)'(MAX_NODES))
        else $error("free node count out of range");

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (child_busy || mark_busy) |-> !child_wr_en && !mark_wr_en && !accept)
        else $error("access during clearing sweep");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result raised outside result stage");

    a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_found_reg && out_full_reg))
        else $error("found and full both set");

endmodule

`default_nettype wire
